/* hdl/bmhq_pkg.sv */
// ----------------------------------------------------------------------------
// Binary max-heap queue package
// Shared widths, status codes and command type.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int unsigned CapacityDef = 128;
  localparam int unsigned IdBitsDef   = 8;
  localparam int unsigned PrioBits    = 16;
  localparam int unsigned PortIdBits  = 8;
  localparam int unsigned CountBits   = 8;

  typedef enum logic [1:0] {
    StPushed  = 2'd0,
    StPopped  = 2'd1,
    StFull    = 2'd2,
    StEmpty   = 2'd3
  } status_e;

  typedef enum logic {
    CmdPush = 1'b0,
    CmdPop  = 1'b1
  } cmd_e;

endpackage

/* hdl/binary_max_heap_queue.sv */
// ----------------------------------------------------------------------------
// Binary max-heap queue
// Priority queue held as an array heap in one synchronous memory.
// ----------------------------------------------------------------------------
// One transfer in gives one result out. The heap lives in one memory that
// does one read and one write per cycle, with read data registered so that
// it arrives in the cycle after the address.
// A push into an empty heap writes the entry straight to the root. Otherwise
// the entry rises: at each level the parent is read and compared, and if the
// new entry is greater the parent is written down one level; the entry is
// written where it stops.
// A pop reads the root as its result and then fetches the last entry. If the
// heap is then empty the pop ends there. Otherwise that entry sinks from the
// root: at each level the left and then the right child are read, the greater
// child is moved up if greater, and the entry is written where it stops.
// A push into a full heap and a pop of an empty one leave the heap unchanged.
// The block takes one item at a time. It accepts a new transfer on the cycle
// after the previous result has been transferred out.
// Entries are ordered by signed priority, and every sift compares strictly,
// so an entry never swaps with one of equal priority.
module binary_max_heap_queue #(
  parameter int unsigned CAPACITY = bmhq_pkg::CapacityDef,
  parameter int unsigned ID_BITS  = bmhq_pkg::IdBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] command, [8:1] from_node, [16:9] to_node, [32:17] priority_req
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [9:2] out_from, [17:10] out_to, [33:18] out_priority,
  // [34] is_empty, [42:35] entry_count
  output logic [47:0] m_axis_tdata
);
  import bmhq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic [PrioBits-1:0] prio;
    logic [ID_BITS-1:0]  src;
    logic [ID_BITS-1:0]  dst;
  } entry_t;

  typedef enum logic [10:0] {
    SIdle    = 11'b00000000001,
    SUpRd    = 11'b00000000010,
    SUpCmp   = 11'b00000000100,
    SUpWr    = 11'b00000001000,
    SPopRd   = 11'b00000010000,
    SPopLast = 11'b00000100000,
    SDnRdL   = 11'b00001000000,
    SDnRdR   = 11'b00010000000,
    SDnCmp   = 11'b00100000000,
    SDnWr    = 11'b01000000000,
    SDone    = 11'b10000000000
  } state_e;

  // memory
  entry_t          mem_q [CAPACITY];
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  entry_t          mem_wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] best_q, best_d;
  entry_t        cur_q, cur_d;    // entry being moved
  entry_t        bestv_q, bestv_d;
  logic          res_valid_q, res_valid_d;
  status_e       res_st_q, res_st_d;
  entry_t        res_e_q, res_e_d;

  logic          in_fire;
  logic [AW+1:0] lidx, ridx, cnt_ext;
  logic [AW-1:0] parent;
  logic          have_l, have_r;

  assign s_axis_tready = (state_q == SIdle) && !res_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign parent        = (pos_q - AW'(1)) >> 1;
  assign lidx          = {1'b0, pos_q, 1'b1};
  assign ridx          = lidx + (AW+2)'(1);
  assign cnt_ext       = (AW+2)'(count_q);
  assign have_l        = lidx < cnt_ext;
  assign have_r        = ridx < cnt_ext;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    best_d      = best_q;
    cur_d       = cur_q;
    bestv_d     = bestv_q;
    res_valid_d = res_valid_q;
    res_st_d    = res_st_q;
    res_e_d     = res_e_q;
    mem_we      = 1'b0;
    mem_waddr   = pos_q;
    mem_wdata   = cur_q;
    mem_raddr   = parent;
    if (res_valid_q && m_axis_tready) begin
      res_valid_d = 1'b0;
    end
    unique case (state_q)
      SIdle: begin
        if (in_fire) begin
          res_e_d = '0;
          if (cmd_e'(s_axis_tdata[0]) == CmdPush) begin
            if (count_q == CW'(CAPACITY)) begin
              res_st_d = StFull;
              state_d  = SDone;
            end else begin
              cur_d.src  = ID_BITS'(s_axis_tdata[8:1]);
              cur_d.dst  = ID_BITS'(s_axis_tdata[16:9]);
              cur_d.prio = s_axis_tdata[32:17];
              pos_d      = AW'(count_q);
              count_d    = count_q + CW'(1);
              res_st_d   = StPushed;
              state_d    = (count_q == '0) ? SUpWr : SUpRd;
            end
          end else begin
            if (count_q == '0) begin
              res_st_d = StEmpty;
              state_d  = SDone;
            end else begin
              mem_raddr = '0;
              count_d   = count_q - CW'(1);
              res_st_d  = StPopped;
              state_d   = SPopRd;
            end
          end
        end
      end
      SUpRd: begin
        mem_raddr = parent;
        state_d   = SUpCmp;
      end
      SUpCmp: begin
        if ($signed(cur_q.prio) > $signed(rdata_q.prio)) begin
          // move parent down, keep rising
          mem_we    = 1'b1;
          mem_waddr = pos_q;
          mem_wdata = rdata_q;
          pos_d     = parent;
          state_d   = (parent == '0) ? SUpWr : SUpRd;
        end else begin
          state_d = SUpWr;
        end
      end
      SUpWr: begin
        mem_we  = 1'b1;
        state_d = SDone;
      end
      SPopRd: begin
        // root data arrives; fetch the last entry
        res_e_d   = rdata_q;
        mem_raddr = AW'(count_q);
        state_d   = SPopLast;
      end
      SPopLast: begin
        cur_d   = rdata_q;
        pos_d   = '0;
        state_d = (count_q == '0) ? SDone : SDnRdL;
      end
      SDnRdL: begin
        if (have_l) begin
          mem_raddr = lidx[AW-1:0];
          state_d   = SDnRdR;
        end else begin
          state_d = SDnWr;
        end
      end
      SDnRdR: begin
        // left child data arrives
        if ($signed(rdata_q.prio) > $signed(cur_q.prio)) begin
          best_d  = lidx[AW-1:0];
          bestv_d = rdata_q;
        end else begin
          best_d  = pos_q;
          bestv_d = cur_q;
        end
        if (have_r) begin
          mem_raddr = ridx[AW-1:0];
        end
        state_d = SDnCmp;
      end
      SDnCmp: begin
        if (have_r && $signed(rdata_q.prio) > $signed(bestv_q.prio)) begin
          mem_we    = 1'b1;
          mem_waddr = pos_q;
          mem_wdata = rdata_q;
          pos_d     = ridx[AW-1:0];
          state_d   = SDnRdL;
        end else if (best_q != pos_q) begin
          mem_we    = 1'b1;
          mem_waddr = pos_q;
          mem_wdata = bestv_q;
          pos_d     = best_q;
          state_d   = SDnRdL;
        end else begin
          state_d = SDnWr;
        end
      end
      SDnWr: begin
        mem_we  = 1'b1;
        state_d = SDone;
      end
      SDone: begin
        res_valid_d = 1'b1;
        state_d     = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      res_valid_q <= 1'b0;
      pos_q       <= '0;
      best_q      <= '0;
      cur_q       <= '0;
      bestv_q     <= '0;
      res_st_q    <= StPushed;
      res_e_q     <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
      pos_q       <= pos_d;
      best_q      <= best_d;
      cur_q       <= cur_d;
      bestv_q     <= bestv_d;
      res_st_q    <= res_st_d;
      res_e_q     <= res_e_d;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {5'd0, CountBits'(count_q), (count_q == '0), res_e_q.prio,
                          PortIdBits'(res_e_q.dst), PortIdBits'(res_e_q.src), res_st_q};

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY)) else $error("count above capacity");
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != SIdle |-> !s_axis_tready) else $error("accept while busy");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result lost");
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("result changed");
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
`endif

endmodule

/* sim/tb_binary_max_heap_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary max-heap queue testbench
// Drives pushes and pops over the input stream, predicts each result with a
// behavioural heap and compares every output transfer field by field.
// ----------------------------------------------------------------------------
module tb_binary_max_heap_queue;
  import bmhq_pkg::*;

  localparam int unsigned Cap      = CapacityDef;
  localparam int unsigned CycleCap = 2000000;
  localparam int unsigned HoldLen  = 300;

  typedef struct packed {
    logic [7:0]  count;
    logic        empty;
    logic [15:0] prio;
    logic [7:0]  dst;
    logic [7:0]  src;
    status_e     status;
  } result_t;

  typedef struct {
    logic signed [15:0] prio;
    logic [7:0]         src;
    logic [7:0]         dst;
  } entry_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  entry_t      heap_q[Cap];
  int unsigned heap_fill;
  result_t     expected_q[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_cycles = 0;
  int unsigned cycle_cnt = 0;
  bit          failed = 1'b0;

  binary_max_heap_queue u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic void swap_entries(int unsigned a, int unsigned b);
    entry_t t;
    t = heap_q[a];
    heap_q[a] = heap_q[b];
    heap_q[b] = t;
  endfunction

  // Apply one command to the heap and return the result it should give.
  function automatic result_t heap_apply(cmd_e cmd, logic [7:0] src, logic [7:0] dst,
                                         logic signed [15:0] prio);
    result_t     r;
    int unsigned pos;
    int unsigned up;
    int unsigned best;
    r = '0;
    if (cmd == CmdPush) begin
      if (heap_fill >= Cap) begin
        r.status = StFull;
      end else begin
        heap_q[heap_fill] = '{prio, src, dst};
        pos = heap_fill;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_q[pos].prio > heap_q[up].prio) begin
            swap_entries(pos, up);
            pos = up;
          end else break;
        end
        heap_fill++;
        r.status = StPushed;
      end
    end else if (heap_fill == 0) begin
      r.status = StEmpty;
    end else begin
      r.status = StPopped;
      r.prio = heap_q[0].prio;
      r.src = heap_q[0].src;
      r.dst = heap_q[0].dst;
      heap_fill--;
      heap_q[0] = heap_q[heap_fill];
      pos = 0;
      while (pos < heap_fill) begin
        best = pos;
        if (2*pos+1 < heap_fill && heap_q[2*pos+1].prio > heap_q[best].prio) best = 2*pos+1;
        if (2*pos+2 < heap_fill && heap_q[2*pos+2].prio > heap_q[best].prio) best = 2*pos+2;
        if (best == pos) break;
        swap_entries(pos, best);
        pos = best;
      end
    end
    r.empty = (heap_fill == 0);
    r.count = heap_fill[7:0];
    return r;
  endfunction

  // Valid stays high between back-to-back transfers; drop it only to idle.
  task automatic send_op(cmd_e cmd, logic [7:0] src, logic [7:0] dst,
                         logic signed [15:0] prio);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, prio, dst, src, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(heap_apply(cmd, src, dst, prio));
  endtask

  task automatic push_rand();
    send_op(CmdPush, 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic drain_wait();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Receiver: random stalls, or a long hold-off counted down here.
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack      <= hold_req;
      hold_cycles   <= HoldLen;
      m_axis_tready <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles   <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[42:0]);
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        failed = 1'b1;
      end else begin
        exp = expected_q.pop_front();
        if (got.status !== exp.status || got.src !== exp.src || got.dst !== exp.dst ||
            got.prio !== exp.prio || got.empty !== exp.empty ||
            got.count !== exp.count) begin
          $display("%0t: mismatch expected st=%0d f=%0d t=%0d p=%0d e=%0d n=%0d",
                   $time, exp.status, exp.src, exp.dst, $signed(exp.prio),
                   exp.empty, exp.count);
          $display("%0t:          actual   st=%0d f=%0d t=%0d p=%0d e=%0d n=%0d",
                   $time, got.status, got.src, got.dst, $signed(got.prio),
                   got.empty, got.count);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleCap) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    send_op(CmdPop, 8'hFF, 8'hFF, 16'sh7FFF);
    send_op(CmdPush, 8'h00, 8'hFF, 16'sh8000);
    send_op(CmdPush, 8'hFF, 8'h00, 16'sh7FFF);
    send_op(CmdPush, 8'hAA, 8'h55, 16'sd5);
    send_op(CmdPush, 8'h55, 8'hAA, 16'sd5);
    send_op(CmdPush, 8'h12, 8'h34, 16'sd5);
    send_op(CmdPush, 8'h01, 8'h02, -16'sd1);
    send_op(CmdPush, 8'h03, 8'h04, 16'sd0);
    repeat (8) send_op(CmdPop, 8'h00, 8'h00, 16'sd0);
  endtask

  // Fill to capacity with ties, overflow, then drain past empty.
  task automatic test_full_and_empty();
    repeat (Cap) send_op(CmdPush, 8'($urandom), 8'($urandom), 16'($urandom_range(3)));
    repeat (2) push_rand();
    repeat (Cap + 2) send_op(CmdPop, 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic test_random(int unsigned n);
    repeat (n) begin
      if ($urandom_range(99) < 55) push_rand();
      else send_op(CmdPop, 8'($urandom), 8'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_backpressure();
    hold_req = hold_req + 1;
    repeat (12) push_rand();
    repeat (12) send_op(CmdPop, 8'h00, 8'h00, 16'sd0);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    heap_fill     = 0;
    send_idle_pct = 32;
    recv_idle_pct = 47;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_and_empty();
    test_random(60);
    send_idle_pct = 47;
    recv_idle_pct = 32;
    test_random(60);
    test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(60);
    drain_wait();
    if (!failed) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
